FILE: hdl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared constants and types for the serial command framer.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEFAULT = 123;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned RUN_IDX_W = $clog2(MAX_RESULTS);
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] ADDR_BYTE = 8'h00;
  localparam logic [7:0] END_MARK = 8'hBB;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  typedef logic [7:0] byte_t;

endpackage

FILE: hdl/serial_command_framer_top.sv
// ----------------------------------------------------------------------------
// serial_command_framer_top
// The first result of an item is valid in the cycle after it is taken.
// Throughput: a start item gives four or six results, a payload item one or
// three, an error one; results leave one per cycle while out_ready is high, so
// the result register sets the rate. The next item is taken in the cycle the
// last result leaves. Reset clears frame and run state, not the result bytes.
// ----------------------------------------------------------------------------
module serial_command_framer_top
  import scf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] command,
  input  logic [6:0] frame_len,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       frame_end,
  output logic       protocol_error
);

  logic                 frame_open;
  logic [6:0]           payload_left;
  byte_t                running_xor;

  logic                 busy;
  byte_t                run_bytes [MAX_RESULTS];
  logic [RUN_CNT_W-1:0] run_count;
  logic [RUN_IDX_W-1:0] run_idx;
  logic                 run_tail;
  logic                 run_err;

  logic                 frame_open_next;
  logic [6:0]           payload_left_next;
  byte_t                running_xor_next;
  byte_t                run_bytes_next [MAX_RESULTS];
  logic [RUN_CNT_W-1:0] run_count_next;
  logic                 run_tail_next;
  logic                 run_err_next;

  logic                 in_fire;
  logic                 run_last;
  logic                 len_bad;
  logic [6:0]           left_dec;
  byte_t                xor_pay;

  assign run_last = (RUN_CNT_W'(run_idx) == run_count - RUN_CNT_W'(1));
  assign in_ready = !busy || (out_ready && run_last);
  assign in_fire = in_valid && in_ready;

  assign out_valid = busy;
  assign out_byte = run_bytes[run_idx];
  assign last_of_run = run_last;
  assign frame_end = run_tail && run_last;
  assign protocol_error = run_err;

  assign len_bad = (frame_len == 7'd0) || ({1'b0, frame_len} > 8'(MAX_FRAME_LEN));
  assign left_dec = payload_left - 7'd1;
  assign xor_pay = running_xor ^ data_byte;

  always_comb begin
    frame_open_next = frame_open;
    payload_left_next = payload_left;
    running_xor_next = running_xor;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      run_bytes_next[i] = 8'h00;
    end
    run_count_next = RUN_CNT_W'(1);
    run_tail_next = 1'b0;
    run_err_next = 1'b0;
    case (op_t'(op))
      OP_START: begin
        if (frame_open || len_bad) begin
          run_err_next = 1'b1;
        end else begin
          frame_open_next = 1'b1;
          payload_left_next = frame_len - 7'd1;
          running_xor_next = ADDR_BYTE ^ {1'b0, frame_len} ^ command;
          run_bytes_next[0] = START_MARK;
          run_bytes_next[1] = ADDR_BYTE;
          run_bytes_next[2] = {1'b0, frame_len};
          run_bytes_next[3] = command;
          run_bytes_next[4] = ADDR_BYTE ^ {1'b0, frame_len} ^ command;
          run_bytes_next[5] = END_MARK;
          if (frame_len == 7'd1) begin
            frame_open_next = 1'b0;
            run_count_next = RUN_CNT_W'(6);
            run_tail_next = 1'b1;
          end else begin
            run_count_next = RUN_CNT_W'(4);
          end
        end
      end
      OP_PAYLOAD: begin
        if (!frame_open) begin
          run_err_next = 1'b1;
        end else begin
          running_xor_next = xor_pay;
          payload_left_next = left_dec;
          run_bytes_next[0] = data_byte;
          run_bytes_next[1] = xor_pay;
          run_bytes_next[2] = END_MARK;
          if (left_dec == 7'd0) begin
            frame_open_next = 1'b0;
            run_count_next = RUN_CNT_W'(3);
            run_tail_next = 1'b1;
          end
        end
      end
      default: begin
        run_err_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      payload_left <= 7'd0;
      running_xor <= 8'h00;
      busy <= 1'b0;
      run_idx <= '0;
      run_count <= RUN_CNT_W'(1);
      run_tail <= 1'b0;
      run_err <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_open <= frame_open_next;
        payload_left <= payload_left_next;
        running_xor <= running_xor_next;
        busy <= 1'b1;
        run_idx <= '0;
        run_count <= run_count_next;
        run_tail <= run_tail_next;
        run_err <= run_err_next;
      end else if (busy && out_ready) begin
        if (run_last) begin
          busy <= 1'b0;
        end else begin
          run_idx <= run_idx + RUN_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        run_bytes[i] <= run_bytes_next[i];
      end
    end
  end

endmodule
